// ----- rtl/mrf_pkg.sv -----
// Shared types and constants for the message ring FIFO.
// Item structs, code enums and parameter defaults; no dependencies.
`timescale 1ns / 1ps

package mrf_pkg;

  localparam int MRF_SLOT_COUNT  = 256;
  localparam int MRF_MAX_PAYLOAD = 32;

  localparam int TS_W  = 64;
  localparam int CTL_W = 16;
  localparam int LEN_W = 7;
  localparam int DROP_W = 32;

  typedef enum logic {
    FUNC_PUSH = 1'b0,
    FUNC_POP  = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_DROP = 2'd1,
    STAT_LONG = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_META,
    ST_STREAM
  } state_t;

  typedef struct packed {
    logic              func;
    logic [TS_W-1:0]   timestamp;
    logic [CTL_W-1:0]  controller_index;
    logic [7:0]        data_byte;
    logic              last;
    logic [LEN_W-1:0]  out_capacity;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [1:0]        status;
    logic [TS_W-1:0]   out_timestamp;
    logic [CTL_W-1:0]  out_controller;
    logic [7:0]        out_byte;
    logic              out_last;
    logic [LEN_W-1:0]  returned_length;
    logic [DROP_W-1:0] drop_total;
  } out_item_t;

  // slot metadata word: length, timestamp, controller
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [TS_W-1:0]   ts;
    logic [CTL_W-1:0]  ctl;
  } meta_t;

endpackage

// ----- rtl/mrf_in_if.sv -----
// Valid/ready channel interface for input items.
// Depends on mrf_pkg for the item struct.
`timescale 1ns / 1ps

interface mrf_in_if import mrf_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// ----- rtl/mrf_out_if.sv -----
// Valid/ready channel interface for result items.
// Depends on mrf_pkg for the item struct.
`timescale 1ns / 1ps

interface mrf_out_if import mrf_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// ----- rtl/mrf_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module mrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/message_ring_fifo_with_drop_count_top.sv -----
// Message ring FIFO top level: push/pop control, pointers, drop counter.
// Depends on mrf_pkg, mrf_in_if, mrf_out_if and mrf_ram.
`timescale 1ns / 1ps

// Usage
// - in_ch carries one item per transfer. func = push: one payload byte, with
//   timestamp/controller_index sampled on a message's first byte and last
//   committing it. func = pop: take the oldest message, up to out_capacity.
// - out_ch returns results. Every push yields one status result (out_last 1).
//   A pop yields n byte results (n = min(length, out_capacity)) with the
//   message's timestamp and controller, or one empty result when the ring is
//   empty or out_capacity is 0. drop_total rides on every result.
// - Push: result is registered in the cycle after the transfer; pushes
//   run one per cycle as long as out_ch keeps taking results.
// - Pop: the transfer starts the metadata and first payload reads, ST_META
//   takes the metadata, then ST_STREAM returns the bytes; both RAMs have a
//   registered read, and the payload RAM streams one byte per cycle while out_ch takes them.
// - A single output register sits on out_ch. in_ch is ready only while the
//   controller is idle and that register is free or being drained; a stall
//   on out_ch freezes the byte stream, RAM read data is held meanwhile.
// - Reset clears pointers, push state and the drop counter. The RAMs are not
//   cleared: a slot is read only after it was committed.
// - Full ring is checked on a message's first byte (drop, counted, saturating);
//   a message over MAX_PAYLOAD bytes is rejected and not counted.

module message_ring_fifo_with_drop_count_top import mrf_pkg::*; #(
  parameter int SLOT_COUNT  = MRF_SLOT_COUNT,
  parameter int MAX_PAYLOAD = MRF_MAX_PAYLOAD
) (
  input logic       clk,
  input logic       rst_n,
  mrf_in_if.sink    in_ch,
  mrf_out_if.source out_ch
);

  localparam int SW = $clog2(SLOT_COUNT);
  localparam int PW = SW + 1;
  localparam int IW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int PAY_DEPTH = SLOT_COUNT << IW;
  localparam int META_W = $bits(meta_t);
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

  // state
  state_t             state_r, state_nxt;
  logic [PW-1:0]      wptr_r, wptr_nxt;
  logic [PW-1:0]      rptr_r, rptr_nxt;
  logic [LEN_W-1:0]   bip_r, bip_nxt;      // bytes taken for current push
  logic               disc_r, disc_nxt;    // discarding rest of message
  logic [DROP_W-1:0]  drops_r, drops_nxt;
  logic [TS_W-1:0]    hold_ts_r, hold_ts_nxt;
  logic [CTL_W-1:0]   hold_ctl_r, hold_ctl_nxt;
  logic [LEN_W-1:0]   cap_r, cap_nxt;
  logic [LEN_W-1:0]   n_r, n_nxt;
  logic [LEN_W-1:0]   idx_r, idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;

  // RAM ports
  logic                meta_we, meta_re;
  logic [SW-1:0]       meta_waddr, meta_raddr;
  meta_t               meta_wdata, meta_rdata;
  logic [META_W-1:0]   meta_rbits;
  logic                pay_we, pay_re;
  logic [SW+IW-1:0]    pay_waddr, pay_raddr;
  logic [7:0]          pay_wdata, pay_rdata;

  // helpers
  logic               out_free;
  logic               accept;
  logic               ring_full, ring_empty;
  logic [PW-1:0]      occ;
  logic [LEN_W-1:0]   len_c, n_c, bip_inc, idx_inc;
  logic               pop_trivial;
  logic               stream_last;

  assign out_free   = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && out_free;
  assign accept     = in_ch.valid && in_ch.ready;
  assign occ        = wptr_r - rptr_r;
  assign ring_full  = occ >= PW'(SLOT_COUNT);
  assign ring_empty = wptr_r == rptr_r;
  assign pop_trivial = (in_ch.item.out_capacity == '0) || ring_empty;
  assign bip_inc    = bip_r + LEN_W'(1);
  assign idx_inc    = idx_r + LEN_W'(1);
  assign meta_rdata = meta_t'(meta_rbits);
  assign len_c      = (meta_rdata.len > MAX_LEN) ? MAX_LEN : meta_rdata.len;
  assign n_c        = (len_c < cap_r) ? len_c : cap_r;
  assign stream_last = idx_inc == n_r;

  assign out_ch.valid = out_valid_r;
  assign out_ch.item  = out_item_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_ch.item.func == FUNC_POP && !pop_trivial) begin
          state_nxt = ST_META;
        end
      end
      ST_META: begin
        if (len_c != '0) begin
          state_nxt = ST_STREAM;
        end else if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_STREAM: begin
        if (out_free && stream_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    wptr_nxt      = wptr_r;
    rptr_nxt      = rptr_r;
    bip_nxt       = bip_r;
    disc_nxt      = disc_r;
    drops_nxt     = drops_r;
    hold_ts_nxt   = hold_ts_r;
    hold_ctl_nxt  = hold_ctl_r;
    cap_nxt       = cap_r;
    n_nxt         = n_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_item_nxt  = out_item_r;

    meta_we    = 1'b0;
    meta_waddr = wptr_r[SW-1:0];
    meta_wdata.len = bip_inc;
    meta_wdata.ts  = (bip_r == '0) ? in_ch.item.timestamp : hold_ts_r;
    meta_wdata.ctl = (bip_r == '0) ? in_ch.item.controller_index : hold_ctl_r;
    meta_re    = 1'b0;
    meta_raddr = rptr_r[SW-1:0];
    pay_we     = 1'b0;
    pay_waddr  = {wptr_r[SW-1:0], bip_r[IW-1:0]};
    pay_wdata  = in_ch.item.data_byte;
    pay_re     = 1'b0;
    pay_raddr  = {rptr_r[SW-1:0], IW'(0)};

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '0;
          out_item_nxt.out_last = 1'b1;
          if (in_ch.item.func == FUNC_PUSH) begin
            out_item_nxt.kind = KIND_PUSH;
            priority if (disc_r) begin
              out_item_nxt.status = (bip_r == '0) ? STAT_DROP : STAT_LONG;
            end else if (bip_r == '0 && ring_full) begin
              if (drops_r != '1) begin
                drops_nxt = drops_r + DROP_W'(1);
              end
              out_item_nxt.status = STAT_DROP;
              disc_nxt = 1'b1;
            end else if (bip_r >= MAX_LEN) begin
              out_item_nxt.status = STAT_LONG;
              disc_nxt = 1'b1;
            end else begin
              out_item_nxt.status = STAT_OK;
              if (bip_r == '0) begin
                hold_ts_nxt  = in_ch.item.timestamp;
                hold_ctl_nxt = in_ch.item.controller_index;
              end
              pay_we  = 1'b1;
              bip_nxt = bip_inc;
              if (in_ch.item.last) begin
                meta_we  = 1'b1;
                wptr_nxt = wptr_r + PW'(1);
              end
            end
            if (in_ch.item.last) begin
              bip_nxt  = '0;
              disc_nxt = 1'b0;
            end
            out_item_nxt.drop_total = drops_nxt;
          end else begin
            out_item_nxt.drop_total = drops_r;
            if (pop_trivial) begin
              out_item_nxt.kind = KIND_EMPTY;
            end else begin
              // start metadata and first payload reads
              out_valid_nxt = out_valid_r && !out_ch.ready;
              out_item_nxt  = out_item_r;
              meta_re = 1'b1;
              pay_re  = 1'b1;
              cap_nxt = in_ch.item.out_capacity;
            end
          end
        end
      end
      ST_META: begin
        if (len_c != '0) begin
          n_nxt   = n_c;
          idx_nxt = '0;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '0;
          out_item_nxt.kind       = KIND_EMPTY;
          out_item_nxt.out_last   = 1'b1;
          out_item_nxt.drop_total = drops_r;
        end
      end
      ST_STREAM: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_item_nxt.kind            = KIND_BYTE;
          out_item_nxt.status          = STAT_OK;
          out_item_nxt.out_timestamp   = meta_rdata.ts;
          out_item_nxt.out_controller  = meta_rdata.ctl;
          out_item_nxt.out_byte        = pay_rdata;
          out_item_nxt.out_last        = stream_last;
          out_item_nxt.returned_length = n_r;
          out_item_nxt.drop_total      = drops_r;
          if (stream_last) begin
            rptr_nxt = rptr_r + PW'(1);
          end else begin
            pay_re    = 1'b1;
            pay_raddr = {rptr_r[SW-1:0], idx_inc[IW-1:0]};
            idx_nxt   = idx_inc;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wptr_r      <= '0;
      rptr_r      <= '0;
      bip_r       <= '0;
      disc_r      <= 1'b0;
      drops_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wptr_r      <= wptr_nxt;
      rptr_r      <= rptr_nxt;
      bip_r       <= bip_nxt;
      disc_r      <= disc_nxt;
      drops_r     <= drops_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_ts_r  <= hold_ts_nxt;
    hold_ctl_r <= hold_ctl_nxt;
    cap_r      <= cap_nxt;
    n_r        <= n_nxt;
    idx_r      <= idx_nxt;
    out_item_r <= out_item_nxt;
  end

  // slot metadata: length, timestamp, controller
  mrf_ram #(
    .WIDTH (META_W),
    .DEPTH (SLOT_COUNT)
  ) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (META_W'(meta_wdata)),
    .re    (meta_re),
    .raddr (meta_raddr),
    .rdata (meta_rbits)
  );

  // payload bytes, addressed {slot, byte index}
  mrf_ram #(
    .WIDTH (8),
    .DEPTH (PAY_DEPTH)
  ) u_pay_ram (
    .clk   (clk),
    .we    (pay_we),
    .waddr (pay_waddr),
    .wdata (pay_wdata),
    .re    (pay_re),
    .raddr (pay_raddr),
    .rdata (pay_rdata)
  );

  // ring occupancy never exceeds the slot count
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ <= PW'(SLOT_COUNT))
    else $error("ring occupancy above slot count");

  // byte stream index stays below the returned length
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_STREAM |-> idx_r < n_r)
    else $error("pop index past returned length");

  // drop counter never goes backwards outside reset
  a_drops_mono: assert property (@(posedge clk)
    rst_n && $past(rst_n) |-> drops_r >= $past(drops_r))
    else $error("drop counter decreased");

  // read pointer only moves on the final byte of a pop
  a_rptr_move: assert property (@(posedge clk) disable iff (!rst_n)
    rptr_r != rptr_nxt |-> state_r == ST_STREAM && stream_last && out_free)
    else $error("read pointer moved outside pop completion");

endmodule
